FILE: rtl/core/kwhm_pkg.sv
// Shared types and constants for the k-way heap merge core.
// Depends on nothing; imported by the front, back, top level and checker.
`timescale 1ns / 1ps

package kwhm_pkg;

    // fixed field widths
    localparam int KEY_W     = 64;
    localparam int COL_OUT_W = 2;
    // widest merge the selection tree is built for
    localparam int MAX_WAYS  = 4;

    typedef logic [KEY_W-1:0] t_key;

    // merge engine sequencer
    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_PICK = 4'b0010,
        S_READ = 4'b0100,
        S_FILL = 4'b1000
    } t_back_state;

endpackage

FILE: rtl/core/k_way_heap_merge_core.sv
// K-way merge core: loads WAYS sorted columns of ROWS 64-bit keys, then
// streams them out merged in ascending order. Depends on kwhm_pkg,
// kwhm_front, kwhm_queue and kwhm_back.
//
// Usage:
//   Slave channel (i_s_*): one key per beat, row-major; key n lands in row
//   n / WAYS, column n % WAYS. Every WAYS*ROWS beats form one batch.
//   Master channel (o_m_*): WAYS*ROWS beats per batch, smallest key first;
//   tuser carries the source column, tlast marks the batch's final key.
//   Equal keys leave in column order, lowest column first.
// Timing:
//   Loading takes one key per cycle via a two-entry queue, while the engine
//   is in its load state. After the last key is loaded, the first result is
//   selected and registered. Each result takes select min, read the store,
//   refill the column head; a pop that empties its column skips the refill.
//   The single read port of the key store sets this order. Next-batch keys
//   queue up (two beats) during a merge and load once its last result is picked.
// Reset: synchronous, active low; queue and output empty, load count zero.
// Stall: a low i_m_tready freezes the output beat and the merge behind it;
//   the input side keeps filling its queue until it is full.
`timescale 1ns / 1ps

module k_way_heap_merge_core import kwhm_pkg::*; #(
    parameter int WAYS = 4,
    parameter int ROWS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [KEY_W-1:0]     i_s_tdata,   // [63:0] key
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [KEY_W-1:0]     o_m_tdata,   // [63:0] sorted_key
    output logic [COL_OUT_W-1:0] o_m_tuser,   // [1:0] source_column
    output logic                 o_m_tlast    // final_key
);

    localparam int BEAT_W = KEY_W + $clog2(WAYS * ROWS) + 2;

    logic              w_f_valid;
    logic              w_f_ready;
    logic [BEAT_W-1:0] w_f_beat;
    logic              w_b_valid;
    logic              w_b_ready;
    logic [BEAT_W-1:0] w_b_beat;

    kwhm_front #(.WAYS(WAYS), .ROWS(ROWS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_q_valid  (w_f_valid),
        .i_q_ready  (w_f_ready),
        .o_q_beat   (w_f_beat)
    );

    kwhm_queue #(.DATA_W(BEAT_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_beat),
        .o_valid (w_b_valid),
        .i_ready (w_b_ready),
        .o_data  (w_b_beat)
    );

    kwhm_back #(.WAYS(WAYS), .ROWS(ROWS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_b_valid),
        .o_q_ready  (w_b_ready),
        .i_q_beat   (w_b_beat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

FILE: rtl/core/kwhm_front.sv
// Input side of the merge core: takes key beats and tags them with their
// store address and row-0 / last-key marks. Depends on kwhm_pkg.
`timescale 1ns / 1ps

module kwhm_front import kwhm_pkg::*; #(
    parameter int WAYS = 4,
    parameter int ROWS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [KEY_W-1:0]                      i_s_tdata,
    output logic                                  o_q_valid,
    input  logic                                  i_q_ready,
    // {last, first_row, addr, key} from the lowest bit up: key, addr, first, last
    output logic [KEY_W+$clog2(WAYS*ROWS)+1:0]    o_q_beat
);

    localparam int TOTAL  = WAYS * ROWS;
    localparam int ADDR_W = $clog2(TOTAL);

    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;
    logic              w_take;
    logic              w_first;
    logic              w_last;

    assign o_s_tready = i_q_ready;
    assign o_q_valid  = i_s_tvalid;
    assign w_take     = i_s_tvalid && i_q_ready;

    // position in the matrix follows from the arrival count
    assign w_first = (r_addr < ADDR_W'(WAYS));
    assign w_last  = (r_addr == ADDR_W'(TOTAL - 1));

    assign o_q_beat = {w_last, w_first, r_addr, i_s_tdata};

    always_comb begin
        n_addr = r_addr;
        if (w_take) begin
            n_addr = w_last ? '0 : r_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else begin
            r_addr <= n_addr;
        end
    end

endmodule

FILE: rtl/core/kwhm_queue.sv
// Two-entry queue between the front and the merge engine.
// Depends on no package; its users import kwhm_pkg.
`timescale 1ns / 1ps

module kwhm_queue #(
    parameter int DATA_W = 72
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_slot [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // payload slots, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/kwhm_back.sv
// Merge engine: key store memory, column heads, min selection and output
// register. Depends on kwhm_pkg.
`timescale 1ns / 1ps

module kwhm_back import kwhm_pkg::*; #(
    parameter int WAYS = 4,
    parameter int ROWS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    output logic                                  o_q_ready,
    input  logic [KEY_W+$clog2(WAYS*ROWS)+1:0]    i_q_beat,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [KEY_W-1:0]                      o_m_tdata,
    output logic [COL_OUT_W-1:0]                  o_m_tuser,
    output logic                                  o_m_tlast
);

    localparam int TOTAL  = WAYS * ROWS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int COL_W  = $clog2(WAYS);
    localparam int NA_W   = ADDR_W + 1;

    // incoming beat fields
    t_key              w_in_key;
    logic [ADDR_W-1:0] w_in_addr;
    logic              w_in_first;
    logic              w_in_last;
    logic              w_load;

    // key store
    t_key              r_mem [TOTAL];
    t_key              r_rdata;
    logic [ADDR_W-1:0] w_rd_addr;

    // column heads: one live entry per column
    t_key              r_head      [WAYS];
    logic [WAYS-1:0]   r_valid;
    logic [NA_W-1:0]   r_next_addr [WAYS];

    t_back_state       r_state;
    logic [COL_W-1:0]  r_col;
    logic [ADDR_W-1:0] r_count;

    logic              r_out_valid;
    t_key              r_out_key;
    logic [COL_OUT_W-1:0] r_out_col;
    logic              r_out_last;
    logic              w_out_free;
    logic              w_last_pop;

    // selection tree slots, padded to the widest merge
    t_key                 s_key [MAX_WAYS];
    logic [MAX_WAYS-1:0]  s_ok;
    t_key                 l1_key [2];
    logic [COL_OUT_W-1:0] l1_col [2];
    logic [1:0]           l1_ok;
    logic                 w_win0;
    logic                 w_win1;
    logic                 w_win2;
    t_key                 w_min_key;
    logic [COL_OUT_W-1:0] w_min_col;

    assign w_in_key   = i_q_beat[KEY_W-1:0];
    assign w_in_addr  = i_q_beat[KEY_W +: ADDR_W];
    assign w_in_first = i_q_beat[KEY_W + ADDR_W];
    assign w_in_last  = i_q_beat[KEY_W + ADDR_W + 1];

    assign o_q_ready  = (r_state == S_LOAD);
    assign w_load     = o_q_ready && i_q_valid;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_last_pop = (r_count == ADDR_W'(TOTAL - 1));

    // pad the tree; unused slots never win
    for (genvar g = 0; g < MAX_WAYS; g++) begin : g_slot
        if (g < WAYS) begin : g_live
            assign s_key[g] = r_head[g];
            assign s_ok[g]  = r_valid[g];
        end else begin : g_pad
            assign s_key[g] = '0;
            assign s_ok[g]  = 1'b0;
        end
    end

    // two compare levels; on equal keys the lower column wins
    assign w_win0 = s_ok[0] && (!s_ok[1] || s_key[0] <= s_key[1]);
    assign w_win1 = s_ok[2] && (!s_ok[3] || s_key[2] <= s_key[3]);
    assign l1_key[0] = w_win0 ? s_key[0] : s_key[1];
    assign l1_col[0] = w_win0 ? COL_OUT_W'(0) : COL_OUT_W'(1);
    assign l1_ok[0]  = s_ok[0] || s_ok[1];
    assign l1_key[1] = w_win1 ? s_key[2] : s_key[3];
    assign l1_col[1] = w_win1 ? COL_OUT_W'(2) : COL_OUT_W'(3);
    assign l1_ok[1]  = s_ok[2] || s_ok[3];
    assign w_win2    = l1_ok[0] && (!l1_ok[1] || l1_key[0] <= l1_key[1]);
    assign w_min_key = w_win2 ? l1_key[0] : l1_key[1];
    assign w_min_col = w_win2 ? l1_col[0] : l1_col[1];

    // refill address for the column just popped
    assign w_rd_addr = r_next_addr[r_col][ADDR_W-1:0];

    // key store: one write port from the queue, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[w_in_addr] <= w_in_key;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // column heads and refill pointers
    always_ff @(posedge i_clk) begin
        if (w_load && w_in_first) begin
            r_head[w_in_addr[COL_W-1:0]]      <= w_in_key;
            r_next_addr[w_in_addr[COL_W-1:0]] <= NA_W'(w_in_addr) + NA_W'(WAYS);
        end else if (r_state == S_READ) begin
            r_next_addr[r_col] <= r_next_addr[r_col] + NA_W'(WAYS);
        end else if (r_state == S_FILL) begin
            r_head[r_col] <= r_rdata;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_PICK && w_out_free) begin
            r_out_key  <= w_min_key;
            r_out_col  <= w_min_col;
            r_out_last <= w_last_pop;
        end
    end

    // sequencer: load, then pick / read / fill per result; an exhausted column skips fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_valid     <= '0;
            r_col       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_load) begin
                        if (w_in_first) begin
                            r_valid[w_in_addr[COL_W-1:0]] <= 1'b1;
                        end
                        if (w_in_last) begin
                            r_count <= '0;
                            r_state <= S_PICK;
                        end
                    end
                end
                S_PICK: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_col       <= COL_W'(w_min_col);
                        r_count     <= r_count + 1'b1;
                        if (w_last_pop) begin
                            r_valid <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // refill from the store, or drop an exhausted column from the heap
                    if (r_next_addr[r_col] < NA_W'(TOTAL)) begin
                        r_state <= S_FILL;
                    end else begin
                        r_valid[r_col] <= 1'b0;
                        r_state <= S_PICK;
                    end
                end
                S_FILL: begin
                    r_state <= S_PICK;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_key;
    assign o_m_tuser  = r_out_col;
    assign o_m_tlast  = r_out_last;

endmodule

FILE: rtl/core/kwhm_checker.sv
// Port-level checks for the k-way merge core, bound to the top level.
// Depends on kwhm_pkg and k_way_heap_merge_core.
`timescale 1ns / 1ps

module kwhm_checker import kwhm_pkg::*; #(
    parameter int WAYS = 4
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [KEY_W-1:0]     o_m_tdata,
    input logic [COL_OUT_W-1:0] o_m_tuser,
    input logic                 o_m_tlast
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output beat changed while stalled");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // reset empties the input queue, so input is ready
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready after reset");

    // tags name a real column
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tuser) < WAYS))
        else $error("source column out of range");

endmodule

bind k_way_heap_merge_core kwhm_checker #(.WAYS(WAYS)) u_kwhm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
